// File: sv/sbs_pkg.sv
// Shared types and constants for the sorted byte set core.
// No dependencies; used by sbs_cell and sorted_byte_set_core.
package sbs_pkg;

  localparam int KeyW   = 8;
  localparam int SizeW  = 5;
  localparam int DataInW  = 8;
  localparam int DataOutW = 8;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic               valid;
    logic               gt;
    logic signed [KeyW-1:0] key;
  } sbs_link_t;

endpackage

// File: sv/sbs_cell.sv
// One slot of the sorted key row: holds a key and a valid bit, compares it
// against the broadcast key and shifts in from its left neighbor.
// Depends on sbs_pkg.
module sbs_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cmp_en,
  input  logic                         ins_en,
  input  logic signed [sbs_pkg::KeyW-1:0] bkey,
  input  sbs_pkg::sbs_link_t           left,
  output sbs_pkg::sbs_link_t           right,
  output logic                         eq
);

  logic                            valid;
  logic signed [sbs_pkg::KeyW-1:0] key;
  logic                            gt;
  logic                            take_left;
  logic                            take_new;

  assign take_left = left.gt;
  assign take_new  = !left.gt && (gt || (!valid && left.valid));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      gt    <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (cmp_en) begin
        eq <= valid && (key == bkey);
        gt <= valid && (bkey < key);
      end
      if (ins_en) begin
        if (take_left || take_new) begin
          valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ins_en) begin
      // shift the larger key up, or drop the new key into the gap
      if (take_left) begin
        key <= left.key;
      end else if (take_new) begin
        key <= bkey;
      end
    end
  end

  assign right.valid = valid;
  assign right.gt    = gt;
  assign right.key   = key;

endmodule

// File: sv/sorted_byte_set_core.sv
// Top level of the sorted byte set: a row of DEPTH key cells with a small
// controller and a registered result word. Depends on sbs_pkg and sbs_cell.
//
// Usage:
//   Input stream (s_*): each word carries a key in s_tdata and a command in
//   s_tuser (insert or membership query). Output stream (m_*): one result
//   word per input word with found, inserted, full_drop and the set size.
//   Each input word goes through these steps: accept, compare in every cell at
//   once, then shift-insert and load the result register. One word is in work
//   at a time, so the next word is not accepted until the current one has
//   finished the compare-then-shift pass through the cell row.
//   s_tready is high while no word is in work; a finished result may still
//   wait in the output register while the next word is taken. If the previous
//   result is still waiting (m_tvalid high, m_tready low) when a new result is
//   due, the block holds the cells and the new result until the old one is taken.
//   Synchronous reset empties the set (all cells invalid, size zero) and
//   clears both handshakes. Only the low five bits of the size are reported.
module sorted_byte_set_core #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [sbs_pkg::DataInW-1:0]  s_tdata,  // [7:0] key
  input  logic                         s_tuser,  // [0] command
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [sbs_pkg::DataOutW-1:0] m_tdata   // [0] found, [1] inserted,
                                                 // [2] full_drop, [7:3] set_size
);

  localparam int CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {IDLE, CMP, APPLY} state_t;

  state_t                           state;
  logic                             cmd;
  logic signed [sbs_pkg::KeyW-1:0]  bkey;
  logic [CntW-1:0]                  count;
  logic [CntW-1:0]                  count_next;
  logic [CntW+sbs_pkg::SizeW-1:0]   count_ext;

  sbs_pkg::sbs_link_t               links [DEPTH+1];
  logic [DEPTH-1:0]                 eq_vec;

  logic cmp_en;
  logic ins_en;
  logic out_free;
  logic found;
  logic full;
  logic do_ins;

  assign s_tready = (state == IDLE) && !rst;
  assign out_free = !m_tvalid || m_tready;
  assign cmp_en   = (state == CMP);
  assign found    = |eq_vec;
  assign full     = links[DEPTH].valid;
  assign do_ins   = (cmd == sbs_pkg::CMD_INSERT) && !found && !full;
  assign ins_en   = (state == APPLY) && out_free && do_ins;

  assign count_next = count + CntW'(do_ins);
  assign count_ext  = (CntW+sbs_pkg::SizeW)'(count_next);

  // left end of the row: always valid, never greater
  assign links[0].valid = 1'b1;
  assign links[0].gt    = 1'b0;
  assign links[0].key   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sbs_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .cmp_en (cmp_en),
      .ins_en (ins_en),
      .bkey   (bkey),
      .left   (links[i]),
      .right  (links[i+1]),
      .eq     (eq_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
      count    <= '0;
    end else begin
      if (state == APPLY && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_tvalid) begin
            state <= CMP;
          end
        end
        CMP: begin
          state <= APPLY;
        end
        APPLY: begin
          // hold until the result register is free
          if (out_free) begin
            count    <= count_next;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd  <= s_tuser;
      bkey <= $signed(s_tdata[sbs_pkg::KeyW-1:0]);
    end
    if (state == APPLY && out_free) begin
      m_tdata <= {count_ext[sbs_pkg::SizeW-1:0],
                  (cmd == sbs_pkg::CMD_INSERT) && !found && full,
                  do_ins,
                  found};
    end
  end

endmodule
